[src/utf16_string_block_parser_top_defines.svh]
// ----------------------------------------------------------------------------
// utf16_string_block_parser_top_defines.svh
// Assertion macros used by the string block parser module usbp_parser.
// ----------------------------------------------------------------------------
`ifndef UTF16_STRING_BLOCK_PARSER_TOP_DEFINES_SVH
`define UTF16_STRING_BLOCK_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define USBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usbp assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define USBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usbp assertion failed");

`else

`define USBP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define USBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/usbp_pkg.sv]
// ----------------------------------------------------------------------------
// usbp_pkg
// Types and constants of the UTF-16 string block parser.
// ----------------------------------------------------------------------------
package usbp_pkg;

    localparam int STRINGS_PER_BLOCK = 16;
    localparam int INDEX_W           = 5;
    localparam int SIZE_W            = 16;
    localparam int ID_W              = 20;
    localparam int STRIDE_SHIFT      = 4;    // 16 strings per block id

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;

    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(STRINGS_PER_BLOCK);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    typedef enum logic [4:0] {
        PH_LEN_LO = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_CHR_LO = 5'b00100,
        PH_CHR_HI = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [15:0]       block_number;
        logic [SIZE_W-1:0] block_bytes;
        logic              end_of_block;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] string_id;
        logic [7:0]      char_code;
        logic            last_char;
    } out_item_t;

    // Result handed from the parser to the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

[src/usbp_in_stage.sv]
// ----------------------------------------------------------------------------
// usbp_in_stage
// Input register: holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module usbp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  usbp_pkg::in_item_t s_item,
    input  logic               take,
    output logic               item_valid,
    output usbp_pkg::in_item_t item
);
    import usbp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register frees up in the same cycle that the parser consumes it.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/usbp_parser.sv]
// ----------------------------------------------------------------------------
// usbp_parser
// Block parse state and the per-byte step that decodes lengths and characters.
// ----------------------------------------------------------------------------
`include "utf16_string_block_parser_top_defines.svh"

module usbp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  usbp_pkg::in_item_t item,
    output usbp_pkg::result_t  result
);
    import usbp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [SIZE_W-1:0]  pos_reg, pos_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [15:0]        rem_reg, rem_next;
    logic [7:0]         held_reg, held_next;

    logic [SIZE_W-1:0]  pos_inc;
    logic [15:0]        word;
    logic [15:0]        rem_dec;
    logic [SIZE_W:0]    room_need;
    logic [SIZE_W+1:0]  span_end;
    logic [15:0]        blk_dec;
    logic [7:0]         narrowed;

    assign pos_inc   = pos_reg + SIZE_W'(1);
    assign word      = {item.data_byte, held_reg};
    assign rem_dec   = rem_reg - 16'd1;
    assign room_need = {1'b0, pos_reg} + (SIZE_W + 1)'(2);
    // Each character takes two bytes, so the length is doubled.
    assign span_end  = {2'b00, pos_inc} + {1'b0, word, 1'b0};
    assign blk_dec   = item.block_number - 16'd1;

    always_comb begin
        if (word == 16'd0) begin
            narrowed = CHAR_SPACE;
        end else if (word[15:8] == 8'd0) begin
            narrowed = word[7:0];
        end else begin
            narrowed = CHAR_UNKNOWN;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        held_next  = held_reg;
        result.valid          = 1'b0;
        result.item.string_id = {blk_dec, {STRIDE_SHIFT{1'b0}}}
                                + {{(ID_W - INDEX_W){1'b0}}, idx_reg};
        result.item.char_code = narrowed;
        result.item.last_char = (rem_dec == 16'd0);

        if (take) begin
            unique case (phase_reg)
                PH_LEN_LO: begin
                    if (idx_reg >= INDEX_LIMIT ||
                        room_need > {1'b0, item.block_bytes}) begin
                        phase_next = PH_DONE;
                    end else begin
                        held_next  = item.data_byte;
                        pos_next   = pos_inc;
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    pos_next = pos_inc;
                    if (word == 16'd0) begin
                        idx_next   = idx_reg + INDEX_W'(1);
                        phase_next = PH_LEN_LO;
                    end else if (span_end > {2'b00, item.block_bytes}) begin
                        phase_next = PH_DONE;
                    end else begin
                        rem_next   = word;
                        phase_next = PH_CHR_LO;
                    end
                end
                PH_CHR_LO: begin
                    held_next  = item.data_byte;
                    pos_next   = pos_inc;
                    phase_next = PH_CHR_HI;
                end
                PH_CHR_HI: begin
                    pos_next     = pos_inc;
                    rem_next     = rem_dec;
                    result.valid = 1'b1;
                    if (rem_dec == 16'd0) begin
                        idx_next   = idx_reg + INDEX_W'(1);
                        phase_next = PH_LEN_LO;
                    end else begin
                        phase_next = PH_CHR_LO;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase

            // The final byte of a block is parsed like any other, then the
            // state starts over for the next block.
            if (item.end_of_block) begin
                phase_next = PH_LEN_LO;
                pos_next   = '0;
                idx_next   = '0;
                rem_next   = '0;
                held_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN_LO;
            pos_reg   <= '0;
            idx_reg   <= '0;
            rem_reg   <= '0;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            held_reg  <= held_next;
        end
    end

    `USBP_ASSERT_NOW(a_result_from_char_high, aclk, aresetn, result.valid, phase_reg == PH_CHR_HI && take)
    `USBP_ASSERT_NEXT(a_block_end_restarts, aclk, aresetn, take && item.end_of_block, phase_reg == PH_LEN_LO && pos_reg == '0 && idx_reg == '0)
    `USBP_ASSERT_NOW(a_index_bounded, aclk, aresetn, 1'b1, idx_reg <= INDEX_LIMIT)
    `USBP_ASSERT_NOW(a_chars_left_in_string, aclk, aresetn, phase_reg == PH_CHR_LO || phase_reg == PH_CHR_HI, rem_reg != 16'd0)

endmodule

[src/usbp_out_stage.sv]
// ----------------------------------------------------------------------------
// usbp_out_stage
// Result register that holds one character until the downstream side takes it.
// ----------------------------------------------------------------------------
module usbp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  usbp_pkg::result_t   result,
    output logic                m_valid,
    input  logic                m_ready,
    output usbp_pkg::out_item_t m_item
);
    import usbp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (result.valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            item_reg <= result.item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

[src/utf16_string_block_parser_top.sv]
// The result register captures a character when the parser takes its high byte from the
// input register. Throughput: one byte item per cycle while the m_ side keeps up.
// The pair of the input register and the result register sets that figure; a held result
// that is not being taken stops the parser, and the input once the input register is full.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the parse state to the length low byte at position zero.
// ----------------------------------------------------------------------------
// utf16_string_block_parser_top
// Streams string-table block bytes in and emits narrowed, tagged characters.
// ----------------------------------------------------------------------------
module utf16_string_block_parser_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte[7:0], block_number[23:8], block_bytes[39:24]
    input  logic [usbp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,   // end_of_block
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // string_id[19:0], char_code[27:20], zero fill[31:28]
    output logic [usbp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast    // last_char
);
    import usbp_pkg::*;

    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      take;
    result_t   result;
    out_item_t m_item;

    assign s_item.data_byte    = s_tdata[7:0];
    assign s_item.block_number = s_tdata[23:8];
    assign s_item.block_bytes  = s_tdata[39:24];
    assign s_item.end_of_block = s_tlast;

    // The held byte moves on whenever the result register is free or draining.
    assign take = item_valid && (!m_tvalid || m_tready);

    usbp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    usbp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .result  (result)
    );

    usbp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .result  (result),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (m_item)
    );

    assign m_tdata = {4'b0000, m_item.char_code, m_item.string_id};
    assign m_tlast = m_item.last_char;

endmodule

[dv/tb_utf16_string_block_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_utf16_string_block_parser_top
// Self-checking bench for the string block parser. A short table of hand-made
// blocks comes first. Random blocks follow: well-formed ones, and ones with
// overruns, cut-off streams, trailing bytes, noise or a changing size. Each
// accepted byte runs through a parser model in the bench, and every emitted
// character is compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_utf16_string_block_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import usbp_pkg::*;

    localparam int          GAP_MAX      = 12;
    localparam int          ITEMS_TOTAL  = 1650;
    localparam int          LONG_HOLD    = 300;
    localparam int          SETTLE       = 10;
    localparam int          DRAIN_EVERY  = 16;
    localparam logic [15:0] NARROW_LIMIT = 16'h0100;

    typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_ONE} row_check_t;

    typedef struct {
        logic [7:0]  data;
        logic [15:0] blk;
        logic [15:0] size;
        logic        eob;
        row_check_t  chk;
        out_item_t   res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Check mode that travels alongside the item currently offered.
    row_check_t tag_chk;
    out_item_t  tag_res;

    // Parser model state.
    phase_t      pb_phase;
    logic [15:0] pb_pos;
    logic [4:0]  pb_index;
    logic [15:0] pb_left;
    logic [7:0]  pb_held;

    out_item_t pending_chars[$];

    int  bytes_accepted = 0;
    int  blocks_sent    = 0;
    int  chars_checked  = 0;
    int  mismatches     = 0;
    bit  send_burst     = 1'b0;
    bit  take_burst     = 1'b0;
    bit  long_hold      = 1'b0;

    // Four small blocks: a space and an empty string followed by an overrun,
    // block number zero with pass-through and unknown characters, size zero,
    // and the largest block number and size.
    dir_row_t dir_rows [20] = '{
        '{8'h01, 16'd1, 16'd8, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd1, 16'd8, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd1, 16'd8, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd1, 16'd8, 1'b0, ROW_ONE,   out_item_t'{20'h00000, 8'h20, 1'b1}},
        '{8'h00, 16'd1, 16'd8, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd1, 16'd8, 1'b0, ROW_NONE,  '0},
        '{8'h05, 16'd1, 16'd8, 1'b0, ROW_MODEL, '0},
        '{8'h00, 16'd1, 16'd8, 1'b1, ROW_MODEL, '0},
        '{8'h02, 16'd0, 16'd6, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd0, 16'd6, 1'b0, ROW_NONE,  '0},
        '{8'hFF, 16'd0, 16'd6, 1'b0, ROW_NONE,  '0},
        '{8'h00, 16'd0, 16'd6, 1'b0, ROW_ONE,   out_item_t'{20'hFFFF0, 8'hFF, 1'b0}},
        '{8'h00, 16'd0, 16'd6, 1'b0, ROW_NONE,  '0},
        '{8'h01, 16'd0, 16'd6, 1'b1, ROW_ONE,   out_item_t'{20'hFFFF0, 8'h3F, 1'b1}},
        '{8'hFF, 16'hFFFF, 16'd0, 1'b0, ROW_NONE, '0},
        '{8'hFF, 16'hFFFF, 16'd0, 1'b1, ROW_NONE, '0},
        '{8'h01, 16'hFFFF, 16'hFFFF, 1'b0, ROW_NONE, '0},
        '{8'h00, 16'hFFFF, 16'hFFFF, 1'b0, ROW_NONE, '0},
        '{8'h41, 16'hFFFF, 16'hFFFF, 1'b0, ROW_NONE, '0},
        '{8'h00, 16'hFFFF, 16'hFFFF, 1'b1, ROW_ONE,  out_item_t'{20'hFFFE0, 8'h41, 1'b1}}
    };

    utf16_string_block_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic reset_parser();
        pb_phase = PH_LEN_LO;
        pb_pos   = '0;
        pb_index = '0;
        pb_left  = '0;
        pb_held  = '0;
    endtask

    // Advances the parser model by one byte; hit is set when a character leaves.
    task automatic parse_byte(input logic [7:0] data, input logic [15:0] blk,
                              input logic [15:0] size, input logic eob,
                              output logic hit, output out_item_t res);
        logic [15:0] word;
        logic [31:0] id_full;
        hit = 1'b0;
        res = '0;
        case (pb_phase)
            PH_LEN_LO: begin
                if (int'(pb_index) >= STRINGS_PER_BLOCK || int'(pb_pos) + 2 > int'(size)) begin
                    pb_phase = PH_DONE;
                end else begin
                    pb_held  = data;
                    pb_pos   = pb_pos + 16'd1;
                    pb_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                word   = {data, pb_held};
                pb_pos = pb_pos + 16'd1;
                if (word == 16'd0) begin
                    pb_index = pb_index + 5'd1;
                    pb_phase = PH_LEN_LO;
                end else if (int'(pb_pos) + 2 * int'(word) > int'(size)) begin
                    // The string would run past the block, so none of it is sent.
                    pb_phase = PH_DONE;
                end else begin
                    pb_left  = word;
                    pb_phase = PH_CHR_LO;
                end
            end
            PH_CHR_LO: begin
                pb_held  = data;
                pb_pos   = pb_pos + 16'd1;
                pb_phase = PH_CHR_HI;
            end
            PH_CHR_HI: begin
                word    = {data, pb_held};
                id_full = (32'(blk) - 32'd1) * 32'd16 + 32'(pb_index);
                pb_pos  = pb_pos + 16'd1;
                pb_left = pb_left - 16'd1;
                res.string_id = id_full[ID_W-1:0];
                if (word == 16'd0)
                    res.char_code = CHAR_SPACE;
                else if (word < NARROW_LIMIT)
                    res.char_code = word[7:0];
                else
                    res.char_code = CHAR_UNKNOWN;
                res.last_char = (pb_left == 16'd0);
                hit = 1'b1;
                if (pb_left == 16'd0) begin
                    pb_index = pb_index + 5'd1;
                    pb_phase = PH_LEN_LO;
                end else begin
                    pb_phase = PH_CHR_LO;
                end
            end
            default: pb_phase = PH_DONE;
        endcase
        if (eob)
            reset_parser();
    endtask

    task automatic take_byte();
        out_item_t got;
        logic      hit;
        bytes_accepted++;
        parse_byte(s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], s_tlast, hit, got);
        case (tag_chk)
            ROW_MODEL: if (hit) pending_chars = {pending_chars, got};
            ROW_ONE:   pending_chars = {pending_chars, tag_res};
            default:   ;
        endcase
    endtask

    task automatic check_char(input logic [31:0] tdata, input logic tlast);
        out_item_t want;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("char %h id %h with nothing pending",
                                      tdata[27:20], tdata[19:0]));
            return;
        end
        want = pending_chars.pop_front();
        chars_checked++;
        if (tdata[19:0] !== want.string_id)
            report_mismatch($sformatf("string_id %h, wanted %h", tdata[19:0], want.string_id));
        if (tdata[27:20] !== want.char_code)
            report_mismatch($sformatf("char_code %h, wanted %h", tdata[27:20], want.char_code));
        if (tlast !== want.last_char)
            report_mismatch($sformatf("last_char %b, wanted %b", tlast, want.last_char));
        if (tdata[31:28] !== 4'h0)
            report_mismatch($sformatf("fill bits %h are not zero", tdata[31:28]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
        end else begin
            if (s_tvalid && s_tready)
                take_byte();
            if (m_tvalid && m_tready)
                check_char(m_tdata, m_tlast);
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(input logic [7:0] data, input logic [15:0] blk,
                             input logic [15:0] size, input logic eob,
                             input row_check_t chk, input out_item_t res);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {size, blk, data};
        s_tlast  <= eob;
        tag_chk  <= chk;
        tag_res  <= res;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random_blocks();
        logic [7:0]  stream[$];
        logic [15:0] blk;
        logic [15:0] size;
        logic [15:0] item_size;
        int          shape;
        int          nstr;
        int          len;
        int          pick;
        int          code;
        int          cut;
        while (bytes_accepted < ITEMS_TOTAL) begin
            stream.delete();
            case ($urandom_range(0, 9))
                0:       blk = 16'h0000;
                1:       blk = 16'hFFFF;
                default: blk = 16'($urandom_range(1, 65535));
            endcase
            send_burst = ($urandom_range(0, 3) == 0);
            if (blocks_sent == 4)
                long_hold = 1'b1;
            shape = $urandom_range(0, 9);
            if (shape >= 8) begin
                repeat ($urandom_range(1, 20)) stream = {stream, 8'($urandom)};
                size = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 24));
            end else begin
                // Mostly a few strings; now and then enough to hit the string limit.
                nstr = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
                repeat (nstr) begin
                    pick = $urandom_range(0, 9);
                    len  = (pick < 3) ? 0 : (pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 12);
                    stream = {stream, 8'(len)};
                    stream = {stream, 8'(len >> 8)};
                    repeat (len) begin
                        case ($urandom_range(0, 3))
                            0:       code = 0;
                            1:       code = $urandom_range(1, 255);
                            default: code = $urandom_range(256, 65535);
                        endcase
                        stream = {stream, 8'(code)};
                        stream = {stream, 8'(code >> 8)};
                    end
                end
                size = 16'(stream.size());
                if (shape == 5) begin
                    // The stream ends early while the size still claims more.
                    cut = $urandom_range(1, stream.size());
                    while (stream.size() > cut) void'(stream.pop_back());
                end else if (shape == 6) begin
                    size = 16'($urandom_range(0, stream.size()));
                end else if (shape == 7) begin
                    repeat ($urandom_range(1, 4)) stream = {stream, 8'($urandom)};
                    size = size + 16'($urandom_range(0, 3));
                end
            end
            foreach (stream[i]) begin
                item_size = size;
                if (shape == 4 && $urandom_range(0, 2) == 0)
                    item_size = 16'($urandom_range(0, int'(size)));
                send_item(stream[i], blk, item_size, i == stream.size() - 1, ROW_MODEL, '0);
            end
            blocks_sent++;
            if (blocks_sent % DRAIN_EVERY == 0)
                wait_for_drain();
        end
    endtask

    // Result side: random stalls, bursts with none, and one long hold-off.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                take_burst = ~take_burst;
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                stall = take_burst ? 0 : $urandom_range(0, GAP_MAX);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        tag_chk  = ROW_MODEL;
        tag_res  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].data, dir_rows[i].blk, dir_rows[i].size, dir_rows[i].eob,
                      dir_rows[i].chk, dir_rows[i].res);
        blocks_sent = 4;
        wait_for_drain();

        send_random_blocks();
        wait_for_drain();
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d byte items in %0d blocks, %0d characters compared.",
                 bytes_accepted, blocks_sent, chars_checked);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d characters still pending.", pending_chars.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
